>>> rtl/core/acrms_pkg.sv
// Shared widths, register codes and reset values for the AC RMS voltmeter.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package acrms_pkg;

  // Fixed field widths of the configuration and result words.
  localparam int WLEN_W     = 11;
  localparam int GAIN_W     = 16;
  localparam int THR_W      = 20;
  localparam int RMS_W      = 19;
  localparam int OFF_OUT_W  = 20;
  localparam int VOLT_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Fraction bits of the Q8 values and of the gain product.
  localparam int FRAC_BITS  = 8;
  localparam int GAIN_FRAC  = 16;

  // Saturation limits of the result fields.
  localparam logic [RMS_W-1:0]  RMS_MAX  = '1;
  localparam logic [VOLT_W-1:0] VOLT_MAX = '1;

  // Register reset values.
  localparam logic [WLEN_W-1:0] WLEN_RST = 11'd500;
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd8623;
  localparam logic [THR_W-1:0]  THR_RST  = 20'd15884;

  // Register index codes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q8       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_Q8  = 2'd2;

endpackage

`default_nettype wire

>>> rtl/core/acrms_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Self-contained; used by the voltmeter top level for both window divisions.
`timescale 1ns / 1ps
`default_nettype none

module acrms_div #(
  parameter int NUM_W = 51,
  parameter int DEN_W = 11
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // One shift-and-subtract step on the partial remainder.
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(diff) : DEN_W'(trial);
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath registers are not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/acrms_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Self-contained; used by the voltmeter top level on the mean square.
`timescale 1ns / 1ps
`default_nettype none

module acrms_sqrt #(
  parameter int VW = 52
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [VW-1:0] val_i,
  output logic               done_o,
  output logic [VW/2-1:0]    root_o
);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [VW-1:0] rad_q, rad_d;
  logic [VW-1:0] root_q, root_d;
  logic [VW-1:0] bit_q, bit_d;
  logic [VW-1:0] trial;

  // Trial subtraction of root plus the current bit.
  assign trial = root_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    rad_d  = rad_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      rad_d  = val_i;
      root_d = '0;
      bit_d  = VW'(1) << (VW - 2);
    end else if (busy_q) begin
      if (rad_q >= trial) begin
        rad_d  = rad_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = root_q[VW/2-1:0];

endmodule

`default_nettype wire

>>> rtl/core/ac_rms_voltmeter_unit.sv
// AC RMS voltmeter top level: sample store, sequencer and shared multiplier.
// Depends on acrms_pkg, acrms_div and acrms_sqrt.
//
// Samples are taken one per clock while the block is collecting. The word that
// completes a window (window_length samples, zero read as one, values above
// MAX_SAMPLES read as MAX_SAMPLES) starts the measurement, and sample_stall_o
// stays high until its result has been placed in the output register.
// SQ_W = 2*(SAMPLE_BITS+8) + clog2(MAX_SAMPLES+1) is the width of the square sum
// and RT_W = ceil(SQ_W/2) that of the root. The measurement runs the offset
// division, a second pass through the sample memory (one read a cycle on its
// single port, feeding the shared multiplier), the mean-square division, the
// square root (one root bit per cycle), the gain product and the load of the
// output register; that load waits while the previous result still waits on
// result_stall_i. Collecting resumes while a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module ac_rms_voltmeter_unit #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Sample input channel
  input  wire logic                             sample_valid_i,
  output logic                                  sample_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]           sample_i,
  // Result output channel
  output logic                                  result_valid_o,
  input  wire logic                             result_stall_i,
  output logic [acrms_pkg::RMS_W-1:0]           rms_q8_o,
  output logic [acrms_pkg::OFF_OUT_W-1:0]       offset_q8_o,
  output logic [acrms_pkg::VOLT_W-1:0]          line_voltage_cv_o,
  output logic                                  signal_present_o,
  // Configuration write channel
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [acrms_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [acrms_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import acrms_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int DEV_W = SAMPLE_BITS + FRAC_BITS;
  localparam int SQ_W  = 2 * DEV_W + CNT_W;
  localparam int VW    = SQ_W + (SQ_W % 2);
  localparam int RT_W  = VW / 2;
  localparam int MW    = (DEV_W > RMS_W) ? DEV_W : RMS_W;
  localparam int LW    = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
  localparam int CW    = RT_W + RMS_W;

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIV_OFF = 3'd1;
  localparam logic [2:0] S_PASS    = 3'd2;
  localparam logic [2:0] S_DIV_MS  = 3'd3;
  localparam logic [2:0] S_SQRT    = 3'd4;
  localparam logic [2:0] S_MUL     = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]             state_q, state_d;
  logic [WLEN_W-1:0]      wlen_q, wlen_d;
  logic [GAIN_W-1:0]      gain_q, gain_d;
  logic [THR_W-1:0]       thr_q, thr_d;
  logic [CNT_W-1:0]       fill_q, fill_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [CNT_W-1:0]       rd_idx_q, rd_idx_d;
  logic                   p1_q, p1_d;
  logic                   p2_q, p2_d;
  logic [SQ_W-1:0]        sq_acc_q, sq_acc_d;
  logic [DEV_W-1:0]       off_q, off_d;
  logic [RMS_W-1:0]       rms_q, rms_d;
  logic                   res_valid_q, res_valid_d;
  logic [RMS_W-1:0]       res_rms_q, res_rms_d;
  logic [OFF_OUT_W-1:0]   res_off_q, res_off_d;
  logic [VOLT_W-1:0]      res_volt_q, res_volt_d;
  logic                   res_pres_q, res_pres_d;

  logic [SAMPLE_BITS-1:0] mem_q [MAX_SAMPLES];
  logic [SAMPLE_BITS-1:0] rd_data_q;
  logic [2*MW-1:0]        prod_q;

  logic                   accept;
  logic                   issue;
  logic                   mul_en;
  logic [CNT_W-1:0]       fill_inc;
  logic [SUM_W-1:0]       sum_inc;
  logic [LW-1:0]          win_ext;
  logic [LW-1:0]          len_eff;
  logic                   close;
  logic [DEV_W-1:0]       smp_q8;
  logic [DEV_W-1:0]       dev;
  logic [MW-1:0]          mul_a;
  logic [MW-1:0]          mul_b;
  logic [2*MW-1:0]        prod_d;
  logic [2*MW-1:0]        volt_raw;
  logic [VOLT_W-1:0]      volt_sat;
  logic                   div_start;
  logic [SQ_W-1:0]        div_num;
  logic [CNT_W-1:0]       div_den;
  logic                   div_done;
  logic [SQ_W-1:0]        div_quo;
  logic                   sqrt_start;
  logic                   sqrt_done;
  logic [RT_W-1:0]        sqrt_root;

  // Handshake terms.
  assign accept         = sample_valid_i && !sample_stall_o;
  assign sample_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;

  // Effective window length and the window-close test.
  assign fill_inc = fill_q + CNT_W'(1);
  assign sum_inc  = sum_q + SUM_W'(sample_i);
  assign win_ext  = LW'(wlen_q);
  always_comb begin
    if (wlen_q == '0) begin
      len_eff = LW'(1);
    end else if (win_ext > LW'(MAX_SAMPLES)) begin
      len_eff = LW'(MAX_SAMPLES);
    end else begin
      len_eff = win_ext;
    end
  end
  assign close = LW'(fill_inc) >= len_eff;

  // Second-pass read issue and pipeline control.
  assign issue  = (state_q == S_PASS) && (rd_idx_q != fill_q);
  assign mul_en = p1_q || (state_q == S_MUL);

  // Deviation of a stored sample from the offset, in Q8 counts.
  assign smp_q8 = {rd_data_q, FRAC_BITS'(0)};
  assign dev    = (smp_q8 >= off_q) ? (smp_q8 - off_q) : (off_q - smp_q8);

  // Shared multiplier: squares deviations, then scales the RMS by the gain.
  assign mul_a  = (state_q == S_MUL) ? MW'(rms_q) : MW'(dev);
  assign mul_b  = (state_q == S_MUL) ? MW'(gain_q) : MW'(dev);
  assign prod_d = (2*MW)'(mul_a) * (2*MW)'(mul_b);

  // Gain product to centivolts, saturated.
  assign volt_raw = prod_q >> GAIN_FRAC;
  assign volt_sat = (volt_raw > (2*MW)'(VOLT_MAX)) ? VOLT_MAX : VOLT_W'(volt_raw);

  // Shared divider operands: window sum for the offset, square sum later.
  assign div_num = (state_q == S_IDLE) ? SQ_W'({sum_inc, FRAC_BITS'(0)}) : sq_acc_q;
  assign div_den = (state_q == S_IDLE) ? fill_inc : fill_q;

  acrms_div #(
    .NUM_W (SQ_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  acrms_sqrt #(
    .VW (VW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (VW'(div_quo)),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // Configuration register writes.
  always_comb begin
    wlen_d = wlen_q;
    gain_d = gain_q;
    thr_d  = thr_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_WINDOW_LENGTH: wlen_d = WLEN_W'(cfg_data_i);
        REG_GAIN_Q8:       gain_d = GAIN_W'(cfg_data_i);
        REG_THRESHOLD_Q8:  thr_d  = THR_W'(cfg_data_i);
        default:           ;
      endcase
    end
  end

  // Sequencer: collect, divide, second pass, divide, root, scale, deliver.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    rd_idx_d    = rd_idx_q;
    p1_d        = issue;
    p2_d        = p1_q;
    sq_acc_d    = sq_acc_q;
    off_d       = off_q;
    rms_d       = rms_q;
    res_valid_d = res_valid_q;
    res_rms_d   = res_rms_q;
    res_off_d   = res_off_q;
    res_volt_d  = res_volt_q;
    res_pres_d  = res_pres_q;
    div_start   = 1'b0;
    sqrt_start  = 1'b0;

    if (res_valid_q && !result_stall_i) begin
      res_valid_d = 1'b0;
    end

    if (issue) begin
      rd_idx_d = rd_idx_q + CNT_W'(1);
    end
    if (p2_q) begin
      sq_acc_d = sq_acc_q + SQ_W'(prod_q);
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          fill_d = fill_inc;
          sum_d  = sum_inc;
          if (close) begin
            div_start = 1'b1;
            state_d   = S_DIV_OFF;
          end
        end
      end
      S_DIV_OFF: begin
        if (div_done) begin
          off_d    = DEV_W'(div_quo);
          rd_idx_d = '0;
          sq_acc_d = '0;
          state_d  = S_PASS;
        end
      end
      S_PASS: begin
        if ((rd_idx_q == fill_q) && !p1_q && !p2_q) begin
          div_start = 1'b1;
          state_d   = S_DIV_MS;
        end
      end
      S_DIV_MS: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_d    = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sqrt_done) begin
          rms_d   = (CW'(sqrt_root) > CW'(RMS_MAX)) ? RMS_MAX : RMS_W'(sqrt_root);
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!res_valid_q || !result_stall_i) begin
          res_valid_d = 1'b1;
          res_rms_d   = rms_q;
          res_off_d   = OFF_OUT_W'(off_q);
          res_volt_d  = volt_sat;
          res_pres_d  = {1'b0, rms_q} >= thr_q;
          fill_d      = '0;
          sum_d       = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wlen_q      <= WLEN_RST;
      gain_q      <= GAIN_RST;
      thr_q       <= THR_RST;
      fill_q      <= '0;
      sum_q       <= '0;
      rd_idx_q    <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wlen_q      <= wlen_d;
      gain_q      <= gain_d;
      thr_q       <= thr_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      rd_idx_q    <= rd_idx_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    sq_acc_q   <= sq_acc_d;
    off_q      <= off_d;
    rms_q      <= rms_d;
    res_rms_q  <= res_rms_d;
    res_off_q  <= res_off_d;
    res_volt_q <= res_volt_d;
    res_pres_q <= res_pres_d;
    if (mul_en) begin
      prod_q <= prod_d;
    end
  end

  // Sample memory: one write port while collecting, one registered read port.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[fill_q[AW-1:0]] <= sample_i;
    end
    rd_data_q <= mem_q[rd_idx_q[AW-1:0]];
  end

  assign result_valid_o    = res_valid_q;
  assign rms_q8_o          = res_rms_q;
  assign offset_q8_o       = res_off_q;
  assign line_voltage_cv_o = res_volt_q;
  assign signal_present_o  = res_pres_q;

endmodule

`default_nettype wire

>>> rtl/core/acrms_checker.sv
// Port-level checks for the AC RMS voltmeter, bound to the top level.
// Depends on acrms_pkg and ac_rms_voltmeter_unit.
`timescale 1ns / 1ps
`default_nettype none

module acrms_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            sample_valid_i,
  input wire logic                            sample_stall_o,
  input wire logic                            result_valid_o,
  input wire logic                            result_stall_i,
  input wire logic [acrms_pkg::RMS_W-1:0]     rms_q8_o,
  input wire logic [acrms_pkg::OFF_OUT_W-1:0] offset_q8_o,
  input wire logic [acrms_pkg::VOLT_W-1:0]    line_voltage_cv_o
);

  // A stalled result word holds its value.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=>
      result_valid_o && $stable(rms_q8_o) && $stable(offset_q8_o) &&
      $stable(line_voltage_cv_o))
    else $error("result word changed while stalled");

  // Measurement starts only on an accepted sample word.
  a_busy_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sample_stall_o) |-> $past(sample_valid_i))
    else $error("input stalled without an accepted sample");

  // A fresh result is loaded only at the end of a measurement.
  a_result_after_measure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> $past(sample_stall_o))
    else $error("result appeared without a measurement");

  // Zero RMS always scales to zero volts.
  a_zero_rms_zero_volt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (rms_q8_o == '0) |-> (line_voltage_cv_o == '0))
    else $error("nonzero voltage for zero RMS");

endmodule

bind ac_rms_voltmeter_unit acrms_checker u_acrms_checker (.*);

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for ac_rms_voltmeter_unit: windows of samples in, RMS readings out.
// Depends on acrms_pkg and the RTL top level; the expected readings come from a predictor
// written here.
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import acrms_pkg::*;

  localparam int SAMPLE_BITS   = 12;
  localparam int MAX_SAMPLES   = 1024;
  localparam int BUF_AW        = $clog2(MAX_SAMPLES);
  // Settle time in drain(), chosen with margin over the longest measurement.
  localparam int SETTLE_CYCLES = 1200;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [RMS_W-1:0]     rms;
    logic [OFF_OUT_W-1:0] offset;
    logic [VOLT_W-1:0]    volt;
    logic                 present;
  } reading_t;

  typedef enum int {WAVE_UNIFORM, WAVE_RAILS, WAVE_NEAR_DC, WAVE_FLAT} wave_style_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   sample_valid_i;
  logic                   sample_stall_o;
  logic [SAMPLE_BITS-1:0] sample_i;
  logic                   result_valid_o;
  logic                   result_stall_i = 1'b0;
  logic [RMS_W-1:0]       rms_q8_o;
  logic [OFF_OUT_W-1:0]   offset_q8_o;
  logic [VOLT_W-1:0]      line_voltage_cv_o;
  logic                   signal_present_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  // Predictor state: register copies and the window being collected.
  logic [WLEN_W-1:0]      wlen_shadow = WLEN_RST;
  logic [GAIN_W-1:0]      gain_shadow = GAIN_RST;
  logic [THR_W-1:0]       thr_shadow  = THR_RST;
  logic [SAMPLE_BITS-1:0] window_buf [MAX_SAMPLES];
  int unsigned            fill_level = 0;
  logic [63:0]            level_sum  = '0;

  reading_t    pending_readings [$];
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  ac_rms_voltmeter_unit #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_valid_i   (sample_valid_i),
    .sample_stall_o   (sample_stall_o),
    .sample_i         (sample_i),
    .result_valid_o   (result_valid_o),
    .result_stall_i   (result_stall_i),
    .rms_q8_o         (rms_q8_o),
    .offset_q8_o      (offset_q8_o),
    .line_voltage_cv_o(line_voltage_cv_o),
    .signal_present_o (signal_present_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Bitwise floor square root, most significant root bit first.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    logic [63:0] square;
    int          b;
    root = '0;
    for (b = 31; b >= 0; b--) begin
      trial  = root | (32'd1 << b);
      square = {32'b0, trial} * {32'b0, trial};
      if (square <= v) root = trial;
    end
    return {32'b0, root};
  endfunction

  // Adds one accepted sample to the window; when it closes, queues the expected reading.
  task automatic absorb_sample(input logic [SAMPLE_BITS-1:0] s);
    int unsigned span;
    int unsigned n;
    int unsigned i;
    logic [63:0] mean_q8;
    logic [63:0] scaled;
    logic [63:0] dev;
    logic [63:0] sq_total;
    logic [63:0] root;
    logic [63:0] volt;
    reading_t    r;
    span = (wlen_shadow == '0) ? 1 :
           (32'(wlen_shadow) > MAX_SAMPLES) ? MAX_SAMPLES : 32'(wlen_shadow);
    if (fill_level < MAX_SAMPLES) begin
      window_buf[BUF_AW'(fill_level)] = s;
      fill_level++;
      level_sum += 64'(s);
    end
    if (fill_level >= span) begin
      n        = fill_level;
      mean_q8  = (level_sum << FRAC_BITS) / 64'(n);
      sq_total = '0;
      for (i = 0; i < n; i++) begin
        scaled   = {52'b0, window_buf[BUF_AW'(i)]} << FRAC_BITS;
        dev      = (scaled >= mean_q8) ? scaled - mean_q8 : mean_q8 - scaled;
        sq_total += dev * dev;
      end
      root = floor_sqrt(sq_total / 64'(n));
      if (root > 64'(RMS_MAX)) root = 64'(RMS_MAX);
      volt = (root * 64'(gain_shadow)) >> GAIN_FRAC;
      if (volt > 64'(VOLT_MAX)) volt = 64'(VOLT_MAX);
      r.rms     = root[RMS_W-1:0];
      r.offset  = mean_q8[OFF_OUT_W-1:0];
      r.volt    = volt[VOLT_W-1:0];
      r.present = (root >= 64'(thr_shadow));
      pending_readings.push_back(r);
      fill_level = 0;
      level_sum  = '0;
    end
  endtask

  task automatic flag_error(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Sends one sample word, with a random idle gap in front of it.
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] s);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= s;
    do @(posedge clk_i); while (sample_stall_o);
    absorb_sample(s);
  endtask

  // Holds the config valid high until the word is taken; cfg_release drops it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_WINDOW_LENGTH: wlen_shadow = data[WLEN_W-1:0];
      REG_GAIN_Q8:       gain_shadow = data[GAIN_W-1:0];
      REG_THRESHOLD_Q8:  thr_shadow  = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    cfg_valid_i <= 1'b0;
  endtask

  // Stops sending, waits for every pending reading and lets the block settle.
  task automatic drain();
    sample_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] wlen,
                               input logic [CFG_DATA_W-1:0] gain,
                               input logic [CFG_DATA_W-1:0] thr);
    drain();
    write_reg(REG_WINDOW_LENGTH, wlen);
    write_reg(REG_GAIN_Q8, gain);
    write_reg(REG_THRESHOLD_Q8, thr);
    cfg_release();
  endtask

  function automatic logic [SAMPLE_BITS-1:0] draw_sample(input wave_style_e style,
                                                         input int unsigned dc);
    int unsigned v;
    case (style)
      WAVE_RAILS:   v = $urandom_range(1) ? 4095 : 0;
      WAVE_NEAR_DC: v = dc + $urandom_range(31);
      WAVE_FLAT:    v = dc;
      default:      v = $urandom_range(4095);
    endcase
    if (v > 4095) v = 4095;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Default gain and threshold, with only the window length changed.
  task automatic test_default_scaling();
    drain();
    write_reg(REG_WINDOW_LENGTH, 20'd4);
    cfg_release();
    push_sample(12'd0);
    push_sample(12'd4095);
    push_sample(12'd4095);
    push_sample(12'd0);
    push_sample(12'd2048);
    push_sample(12'd2049);
    push_sample(12'd2047);
    push_sample(12'd2048);
  endtask

  // One-sample windows, a zero length read as one, and gain and threshold extremes.
  task automatic test_short_windows();
    load_settings(20'd1, 20'd65535, 20'd0);
    push_sample(12'd4095);
    push_sample(12'd0);
    load_settings(20'd2, 20'd0, 20'hFFFFF);
    push_sample(12'd0);
    push_sample(12'd4095);
    load_settings(20'd0, 20'd65535, 20'd1);
    push_sample(12'd2048);
  endtask

  // A window cut short: the length drops below what is already collected.
  task automatic test_length_lowered();
    int k;
    load_settings(20'd1024, 20'd30000, 20'd100000);
    for (k = 0; k < 6; k++) push_sample(SAMPLE_BITS'($urandom_range(4095)));
    load_settings(20'd3, 20'd30000, 20'd100000);
    push_sample(SAMPLE_BITS'($urandom_range(4095)));
  endtask

  // A length above the store size, with the top data bits set, keeps the window open;
  // a short length written afterwards closes it on the next word.
  task automatic test_length_over_max();
    int k;
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    load_settings(20'hFFFFF, 20'd8623, 20'd200000);
    for (k = 0; k < 100; k++) push_sample(SAMPLE_BITS'($urandom_range(4095)));
    load_settings(20'd3, 20'd8623, 20'd200000);
    push_sample(SAMPLE_BITS'($urandom_range(4095)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Random settings and waveforms; partial windows carry over into the next setting.
  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned budget);
    int unsigned sent;
    int unsigned seg_len;
    int unsigned dc;
    int unsigned pick;
    int unsigned k;
    logic [CFG_DATA_W-1:0] wlen;
    logic [CFG_DATA_W-1:0] gain;
    logic [CFG_DATA_W-1:0] thr;
    wave_style_e style;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      wlen = (pick < 70) ? CFG_DATA_W'($urandom_range(16, 1)) :
             (pick < 85) ? CFG_DATA_W'($urandom_range(120, 17)) :
             (pick < 92) ? 20'd0 : CFG_DATA_W'($urandom_range(400, 200));
      pick = $urandom_range(99);
      gain = (pick < 10) ? 20'd0 : (pick < 20) ? 20'd65535 :
             CFG_DATA_W'($urandom_range(65535));
      pick = $urandom_range(99);
      thr  = (pick < 10) ? 20'd0 : (pick < 20) ? 20'hFFFFF :
             CFG_DATA_W'($urandom_range(330000));
      load_settings(wlen, gain, thr);
      style   = wave_style_e'($urandom_range(3));
      dc      = $urandom_range(4095);
      seg_len = $urandom_range(48, 8);
      for (k = 0; k < seg_len; k++) push_sample(draw_sample(style, dc));
      sent += seg_len;
    end
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0, 170);
    run_phase(61, 0, 170);
    run_phase(0, 61, 170);
    run_phase(38, 38, 170);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Result side stalls at random.
  always @(posedge clk_i) begin
    result_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compares each result word taken with the oldest pending reading.
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && result_valid_o && !result_stall_i) begin
      if (pending_readings.size() == 0) begin
        flag_error($sformatf("unexpected reading rms=%0d offset=%0d",
                             rms_q8_o, offset_q8_o));
      end else begin
        want = pending_readings.pop_front();
        if (rms_q8_o !== want.rms)
          flag_error($sformatf("rms_q8 got %0d want %0d", rms_q8_o, want.rms));
        if (offset_q8_o !== want.offset)
          flag_error($sformatf("offset_q8 got %0d want %0d", offset_q8_o, want.offset));
        if (line_voltage_cv_o !== want.volt)
          flag_error($sformatf("line_voltage_cv got %0d want %0d",
                               line_voltage_cv_o, want.volt));
        if (signal_present_o !== want.present)
          flag_error($sformatf("signal_present got %0d want %0d",
                               signal_present_o, want.present));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    sample_valid_i <= 1'b0;
    sample_i       <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= REG_WINDOW_LENGTH;
    cfg_data_i     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_scaling();
    test_short_windows();
    test_length_lowered();
    test_length_over_max();
    test_random_traffic();

    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
